/* sv/segment_intersection_point_assert.svh */
// Assertion macros for the segment intersection block.
`ifndef SEGMENT_INTERSECTION_POINT_ASSERT_SVH
`define SEGMENT_INTERSECTION_POINT_ASSERT_SVH

// The consequent must hold whenever the antecedent holds at a clock edge.
`define SIP_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never hold at a clock edge.
`define SIP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* sv/sip_pkg.sv */
// Shared types for the segment intersection block.
`default_nettype none

package sip_pkg;

  // Control that travels alongside each beat through the divider.
  typedef struct packed {
    logic valid;
    logic neg;
    logic hit;
    logic parallel;
  } div_ctl_t;

endpackage

`default_nettype wire

/* sv/sip_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with signed offset add.
`default_nettype none

module sip_div import sip_pkg::*; #(
  parameter int DVD_W = 52,
  parameter int DVS_W = 35,
  parameter int QB    = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire div_ctl_t                ctl_in,
  input  wire logic [DVD_W-1:0]        dvd_in,
  input  wire logic [DVS_W-1:0]        dvs_in,
  input  wire logic signed [QB-1:0]    base_in,
  output div_ctl_t                     ctl_out,
  output logic signed [QB-1:0]         coord
);

  localparam int XW = DVD_W + QB;

  div_ctl_t                 ctl  [QB+1];
  logic [DVD_W-1:0]         rem  [QB+1];
  logic [QB-1:0]            quo  [QB+1];
  logic [DVS_W-1:0]         dvs  [QB+1];
  logic signed [QB-1:0]     base [QB+1];

  logic [QB:0]              q_ext;
  logic [QB:0]              q_sgn;

  // Input register of the divider; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= ctl_in.valid;
    end
    ctl[0].neg      <= ctl_in.neg;
    ctl[0].hit      <= ctl_in.hit;
    ctl[0].parallel <= ctl_in.parallel;
    rem[0]          <= dvd_in;
    quo[0]          <= '0;
    dvs[0]          <= dvs_in;
    base[0]         <= base_in;
  end

  // One stage per quotient bit, most significant bit first.
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BI = QB - 1 - k;
    logic [XW-1:0]    shifted;
    logic             take;
    logic [XW-1:0]    diff;
    logic [QB-1:0]    quo_next;

    always_comb begin
      shifted      = XW'(dvs[k]) << BI;
      take         = XW'(rem[k]) >= shifted;
      diff         = XW'(rem[k]) - shifted;
      quo_next     = quo[k];
      quo_next[BI] = take;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1].valid <= 1'b0;
      end else begin
        ctl[k+1].valid <= ctl[k].valid;
      end
      ctl[k+1].neg      <= ctl[k].neg;
      ctl[k+1].hit      <= ctl[k].hit;
      ctl[k+1].parallel <= ctl[k].parallel;
      rem[k+1]          <= take ? diff[DVD_W-1:0] : rem[k];
      quo[k+1]          <= quo_next;
      dvs[k+1]          <= dvs[k];
      base[k+1]         <= base[k];
    end
  end

  // Apply the sign to the quotient and add the segment start.
  always_comb begin
    q_ext = {1'b0, quo[QB]};
    q_sgn = ctl[QB].neg ? (~q_ext + 1'b1) : q_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl[QB].valid;
    end
    ctl_out.neg      <= ctl[QB].neg;
    ctl_out.hit      <= ctl[QB].hit;
    ctl_out.parallel <= ctl[QB].parallel;
    coord            <= base[QB] + $signed(q_sgn[QB-1:0]);
  end

endmodule

`default_nettype wire

/* sv/segment_intersection_point.sv */
// Top level of the pipelined two-segment intersection block.
//
//  Channel   Handshake          Payload
//  input     start / busy       first_*, second_* endpoints
//  result    done (strobe)      hit, parallel, cross_x, cross_y
//
// Every beat passes four front stages (box test and differences, cross products,
// denominator and numerators, ratio checks), then the divider with an input
// register, one stage per quotient bit and a final offset add.
// A new beat may enter every cycle; busy stays low.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so results leave on the done strobe.
`default_nettype none

module segment_intersection_point import sip_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_BITS-1:0]  first_start_x,
  input  wire logic signed [COORD_BITS-1:0]  first_start_y,
  input  wire logic signed [COORD_BITS-1:0]  first_end_x,
  input  wire logic signed [COORD_BITS-1:0]  first_end_y,
  input  wire logic signed [COORD_BITS-1:0]  second_start_x,
  input  wire logic signed [COORD_BITS-1:0]  second_start_y,
  input  wire logic signed [COORD_BITS-1:0]  second_end_x,
  input  wire logic signed [COORD_BITS-1:0]  second_end_y,
  output logic                               done,
  output logic                               hit,
  output logic                               parallel,
  output logic signed [COORD_BITS-1:0]       cross_x,
  output logic signed [COORD_BITS-1:0]       cross_y
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int MW = NW + DW;

  // Stage one: box test and differences.
  logic signed [CW-1:0] max1x, min1x, max2x, min2x;
  logic signed [CW-1:0] max1y, min1y, max2y, min2y;
  logic                 box_ok_next;

  logic                 v1;
  logic                 box1;
  logic signed [DW-1:0] dx1_1, dy1_1, dx2_1, dy2_1, ox_1, oy_1;
  logic signed [CW-1:0] sx_1, sy_1;

  // Stage two: cross products.
  logic                 v2;
  logic                 box2;
  logic signed [PW-1:0] pa_2, pb_2, pc_2, pd_2, pe_2, pf_2;
  logic signed [DW-1:0] dx1_2, dy1_2;
  logic signed [CW-1:0] sx_2, sy_2;

  // Stage three: denominator and numerators.
  logic                 v3;
  logic                 box3;
  logic signed [NW-1:0] den_3, na_3, nb_3;
  logic signed [DW-1:0] dx1_3, dy1_3;
  logic signed [CW-1:0] sx_3, sy_3;

  // Stage four: ratio checks and dividend products.
  logic signed [NW-1:0] na_n, nb_n, den_n;
  logic                 ok_a, ok_b, den_zero;

  logic                 v4;
  logic                 hit4, par4;
  logic signed [MW-1:0] px_4, py_4;
  logic signed [NW-1:0] den_4;
  logic signed [CW-1:0] sx_4, sy_4;

  // Divider feed.
  logic [MW-1:0]        mpx, mpy;
  logic [NW-1:0]        md;
  div_ctl_t             ctl_xi, ctl_yi, ctl_x, ctl_y;
  logic signed [CW-1:0] coord_x, coord_y;

  assign busy = 1'b0;

  // Box bounds; touching boxes count as overlapping.
  always_comb begin
    max1x = (first_start_x > first_end_x) ? first_start_x : first_end_x;
    min1x = (first_start_x > first_end_x) ? first_end_x : first_start_x;
    max2x = (second_start_x > second_end_x) ? second_start_x : second_end_x;
    min2x = (second_start_x > second_end_x) ? second_end_x : second_start_x;
    max1y = (first_start_y > first_end_y) ? first_start_y : first_end_y;
    min1y = (first_start_y > first_end_y) ? first_end_y : first_start_y;
    max2y = (second_start_y > second_end_y) ? second_start_y : second_end_y;
    min2y = (second_start_y > second_end_y) ? second_end_y : second_start_y;
    box_ok_next = !((max1x < min2x) || (max2x < min1x) ||
                    (max1y < min2y) || (max2y < min1y));
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    box1  <= box_ok_next;
    dx1_1 <= DW'(first_end_x) - DW'(first_start_x);
    dy1_1 <= DW'(first_end_y) - DW'(first_start_y);
    dx2_1 <= DW'(second_end_x) - DW'(second_start_x);
    dy2_1 <= DW'(second_end_y) - DW'(second_start_y);
    ox_1  <= DW'(first_start_x) - DW'(second_start_x);
    oy_1  <= DW'(first_start_y) - DW'(second_start_y);
    sx_1  <= first_start_x;
    sy_1  <= first_start_y;
  end

  // Stage two payload.
  always_ff @(posedge clk) begin
    box2  <= box1;
    pa_2  <= dy2_1 * dx1_1;
    pb_2  <= dx2_1 * dy1_1;
    pc_2  <= dx2_1 * oy_1;
    pd_2  <= dy2_1 * ox_1;
    pe_2  <= dx1_1 * oy_1;
    pf_2  <= dy1_1 * ox_1;
    dx1_2 <= dx1_1;
    dy1_2 <= dy1_1;
    sx_2  <= sx_1;
    sy_2  <= sy_1;
  end

  // Stage three payload.
  always_ff @(posedge clk) begin
    box3  <= box2;
    den_3 <= NW'(pa_2) - NW'(pb_2);
    na_3  <= NW'(pc_2) - NW'(pd_2);
    nb_3  <= NW'(pe_2) - NW'(pf_2);
    dx1_3 <= dx1_2;
    dy1_3 <= dy1_2;
    sx_3  <= sx_2;
    sy_3  <= sy_2;
  end

  // Both parameters must lie in 0..1: fold the sign of the denominator in.
  always_comb begin
    den_zero = (den_3 == '0);
    na_n     = den_3[NW-1] ? -na_3 : na_3;
    nb_n     = den_3[NW-1] ? -nb_3 : nb_3;
    den_n    = den_3[NW-1] ? -den_3 : den_3;
    ok_a     = !na_n[NW-1] && !(den_n < na_n);
    ok_b     = !nb_n[NW-1] && !(den_n < nb_n);
  end

  // Stage four payload.
  always_ff @(posedge clk) begin
    hit4  <= box3 && !den_zero && ok_a && ok_b;
    par4  <= box3 && den_zero;
    px_4  <= na_3 * dx1_3;
    py_4  <= na_3 * dy1_3;
    den_4 <= den_3;
    sx_4  <= sx_3;
    sy_4  <= sy_3;
  end

  // Magnitudes and quotient signs for the dividers.
  always_comb begin
    mpx = px_4[MW-1] ? MW'(-px_4) : MW'(px_4);
    mpy = py_4[MW-1] ? MW'(-py_4) : MW'(py_4);
    md  = den_4[NW-1] ? NW'(-den_4) : NW'(den_4);

    ctl_xi.valid    = v4;
    ctl_xi.neg      = px_4[MW-1] ^ den_4[NW-1];
    ctl_xi.hit      = hit4;
    ctl_xi.parallel = par4;

    ctl_yi.valid    = v4;
    ctl_yi.neg      = py_4[MW-1] ^ den_4[NW-1];
    ctl_yi.hit      = hit4;
    ctl_yi.parallel = par4;
  end

  sip_div #(
    .DVD_W (MW),
    .DVS_W (NW),
    .QB    (CW)
  ) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_xi),
    .dvd_in  (mpx),
    .dvs_in  (md),
    .base_in (sx_4),
    .ctl_out (ctl_x),
    .coord   (coord_x)
  );

  sip_div #(
    .DVD_W (MW),
    .DVS_W (NW),
    .QB    (CW)
  ) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_yi),
    .dvd_in  (mpy),
    .dvs_in  (md),
    .base_in (sy_4),
    .ctl_out (ctl_y),
    .coord   (coord_y)
  );

  // Result beat; the point reads zero unless there is a hit.
  always_comb begin
    done     = ctl_x.valid;
    hit      = ctl_x.hit;
    parallel = ctl_x.parallel;
    cross_x  = ctl_x.hit ? coord_x : '0;
    cross_y  = ctl_y.hit ? coord_y : '0;
  end

  `include "segment_intersection_point_assert.svh"

  `SIP_NEVER(a_hit_par, done && hit && parallel, "hit and parallel both set")
  `SIP_CHECK(a_miss_zero, done && !hit, cross_x == '0 && cross_y == '0, "miss with nonzero point")
  `SIP_CHECK(a_lanes_align, ctl_x.valid || ctl_y.valid, ctl_x.valid == ctl_y.valid && ctl_x.hit == ctl_y.hit, "divider lanes out of step")

endmodule

`default_nettype wire
